[sv/pfci_pkg.sv]
// Package for the parallel flash command interface: field widths, command
// codes, one-hot state types and the control/status structs.
// No dependencies.
package pfci_pkg;

    // Default geometry (powers of two)
    localparam int unsigned ARRAY_BYTES_DEF  = 262144;
    localparam int unsigned SECTOR_BYTES_DEF = 4096;
    localparam int unsigned BLOCK_BYTES_DEF  = 65536;

    // Field widths
    localparam int unsigned ADDR_W = 18;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // Bus addresses and command bytes
    localparam logic [15:0] ADDR_UNLOCK_A = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK_B = 16'h2AAA;
    localparam logic [7:0]  CMD_UNLOCK_A  = 8'hAA;
    localparam logic [7:0]  CMD_UNLOCK_B  = 8'h55;
    localparam logic [7:0]  CMD_ID_ENTRY  = 8'h90;
    localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
    localparam logic [7:0]  CMD_ERASE     = 8'h80;
    localparam logic [7:0]  CMD_SECTOR    = 8'h30;
    localparam logic [7:0]  CMD_BLOCK     = 8'h50;
    localparam logic [7:0]  CMD_CHIP      = 8'h10;
    localparam logic [7:0]  CMD_RESET     = 8'hF0;
    localparam logic [7:0]  STATUS_TOGGLE = 8'h40;
    localparam logic [7:0]  ERASED_BYTE   = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MANUF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_BR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_BR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_EN  = 3'd5;

    // Command decode phases
    typedef enum logic [6:0] {
        PH_IDLE           = 7'b0000001,
        PH_UNLOCK_A       = 7'b0000010,
        PH_COMMAND        = 7'b0000100,
        PH_PROGRAM        = 7'b0001000,
        PH_ERASE_SETUP    = 7'b0010000,
        PH_ERASE_UNLOCK_A = 7'b0100000,
        PH_ERASE_COMMAND  = 7'b1000000
    } t_phase;

    // Sequencer states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FETCH = 6'b000100,
        S_EXEC  = 6'b001000,
        S_ERASE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        ER_SECTOR = 2'd0,
        ER_BLOCK  = 2'd1,
        ER_CHIP   = 2'd2
    } t_erase_kind;

    // Controller to datapath
    typedef struct packed {
        logic              capture;
        logic              prog_wr;
        logic              erase_start;
        t_erase_kind       erase_kind;
        logic              res_load;
        logic              res_use_mem;
        logic [DATA_W-1:0] res_byte;
        logic              res_busy;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic              op;
        logic              addr_lsb;
        logic [15:0]       low16;
        logic [DATA_W-1:0] data;
        logic              sweep_active;
    } t_dp_stat;

endpackage

[sv/pfci_if.sv]
// Valid/ready channel interfaces for bus accesses and their results.
// Depends on pfci_pkg.
interface pfci_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [pfci_pkg::ADDR_W-1:0]  address;
    logic [pfci_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, op, address, write_data, input ready);
    modport sink   (input valid, op, address, write_data, output ready);
endinterface

interface pfci_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pfci_pkg::DATA_W-1:0]  read_data;
    logic                         busy_res;

    modport source (output valid, read_data, busy_res, input ready);
    modport sink   (input valid, read_data, busy_res, output ready);
endinterface

[sv/pfci_ctrl.sv]
// Controller: sequencer, command decode, busy counter, toggle bit and
// configuration registers. Depends on pfci_pkg.
module pfci_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfci_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfci_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  pfci_pkg::t_dp_stat             i_stat,
    output pfci_pkg::t_ctrl_cmd            o_cmd
);
    import pfci_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_id, n_id;
    logic   r_toggle, n_toggle;
    logic [7:0] r_busy, n_busy;

    logic [7:0] r_manuf, r_device, r_prog_br, r_erase_br;
    logic       r_block_en, r_chip_en;

    logic at_a, at_b;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign at_a = (i_stat.low16 == ADDR_UNLOCK_A);
    assign at_b = (i_stat.low16 == ADDR_UNLOCK_B);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf    <= 8'hBF;
            r_device   <= 8'h5B;
            r_prog_br  <= 8'd4;
            r_erase_br <= 8'd16;
            r_block_en <= 1'b1;
            r_chip_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MANUF:    r_manuf    <= i_cfg_data;
                CFG_DEVICE:   r_device   <= i_cfg_data;
                CFG_PROG_BR:  r_prog_br  <= i_cfg_data;
                CFG_ERASE_BR: r_erase_br <= i_cfg_data;
                CFG_BLOCK_EN: r_block_en <= i_cfg_data[0];
                CFG_CHIP_EN:  r_chip_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer and command decode
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_id     = r_id;
        n_toggle = r_toggle;
        n_busy   = r_busy;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                if (!i_stat.sweep_active) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                o_cmd.res_load = 1'b1;
                n_state = S_OUT;
                if (!i_stat.op) begin
                    // read access
                    if (r_busy != 8'd0) begin
                        o_cmd.res_byte = r_toggle ? STATUS_TOGGLE : 8'h00;
                        o_cmd.res_busy = 1'b1;
                        n_toggle = ~r_toggle;
                        n_busy   = r_busy - 8'd1;
                    end else if (r_id) begin
                        o_cmd.res_byte = i_stat.addr_lsb ? r_device : r_manuf;
                    end else begin
                        o_cmd.res_use_mem = 1'b1;
                    end
                end else begin
                    // write access, ignored while busy
                    if (r_busy == 8'd0) begin
                        if (r_phase == PH_PROGRAM) begin
                            o_cmd.prog_wr = 1'b1;
                            n_busy  = r_prog_br;
                            n_phase = PH_IDLE;
                        end else if (i_stat.data == CMD_RESET) begin
                            n_phase = PH_IDLE;
                            n_id    = 1'b0;
                        end else begin
                            case (r_phase)
                                PH_IDLE: begin
                                    if (at_a && i_stat.data == CMD_UNLOCK_A)
                                        n_phase = PH_UNLOCK_A;
                                end
                                PH_UNLOCK_A: begin
                                    n_phase = (at_b && i_stat.data == CMD_UNLOCK_B) ?
                                              PH_COMMAND : PH_IDLE;
                                end
                                PH_COMMAND: begin
                                    n_phase = PH_IDLE;
                                    if (!at_a) begin
                                        n_id = 1'b0;
                                    end else if (i_stat.data == CMD_ID_ENTRY) begin
                                        n_id = 1'b1;
                                    end else if (i_stat.data == CMD_PROGRAM) begin
                                        n_id = 1'b0;
                                        n_phase = PH_PROGRAM;
                                    end else if (i_stat.data == CMD_ERASE) begin
                                        n_id = 1'b0;
                                        n_phase = PH_ERASE_SETUP;
                                    end else begin
                                        n_id = 1'b0;
                                    end
                                end
                                PH_ERASE_SETUP: begin
                                    n_phase = (at_a && i_stat.data == CMD_UNLOCK_A) ?
                                              PH_ERASE_UNLOCK_A : PH_IDLE;
                                end
                                PH_ERASE_UNLOCK_A: begin
                                    n_phase = (at_b && i_stat.data == CMD_UNLOCK_B) ?
                                              PH_ERASE_COMMAND : PH_IDLE;
                                end
                                PH_ERASE_COMMAND: begin
                                    n_phase = PH_IDLE;
                                    if (i_stat.data == CMD_SECTOR) begin
                                        o_cmd.erase_start = 1'b1;
                                        o_cmd.erase_kind  = ER_SECTOR;
                                    end else if (i_stat.data == CMD_BLOCK && r_block_en) begin
                                        o_cmd.erase_start = 1'b1;
                                        o_cmd.erase_kind  = ER_BLOCK;
                                    end else if (i_stat.data == CMD_CHIP && r_chip_en
                                                 && at_a) begin
                                        o_cmd.erase_start = 1'b1;
                                        o_cmd.erase_kind  = ER_CHIP;
                                    end else begin
                                        n_id = 1'b0;
                                    end
                                    if (o_cmd.erase_start) begin
                                        n_busy  = r_erase_br;
                                        n_state = S_ERASE;
                                    end
                                end
                                default: n_phase = PH_IDLE;
                            endcase
                        end
                    end
                    o_cmd.res_busy = (n_busy != 8'd0);
                end
            end
            S_ERASE: begin
                if (!i_stat.sweep_active) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_phase  <= PH_IDLE;
            r_id     <= 1'b0;
            r_toggle <= 1'b0;
            r_busy   <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_id     <= n_id;
            r_toggle <= n_toggle;
            r_busy   <= n_busy;
        end
    end

endmodule

[sv/pfci_dp.sv]
// Datapath: captured access, byte-wide flash array memory, erase sweep
// and result register. Depends on pfci_pkg.
module pfci_dp #(
    parameter int unsigned ARRAY_BYTES  = pfci_pkg::ARRAY_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = pfci_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES  = pfci_pkg::BLOCK_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_op,
    input  logic [pfci_pkg::ADDR_W-1:0]  i_address,
    input  logic [pfci_pkg::DATA_W-1:0]  i_write_data,
    input  pfci_pkg::t_ctrl_cmd          i_cmd,
    output pfci_pkg::t_dp_stat           o_stat,
    output logic [pfci_pkg::DATA_W-1:0]  o_read_data,
    output logic                         o_busy_res
);
    import pfci_pkg::*;

    localparam int unsigned AW = $clog2(ARRAY_BYTES);
    localparam logic [AW-1:0] SEC_MASK = (SECTOR_BYTES >= ARRAY_BYTES) ?
                                         {AW{1'b1}} : AW'(SECTOR_BYTES - 1);
    localparam logic [AW-1:0] BLK_MASK = (BLOCK_BYTES >= ARRAY_BYTES) ?
                                         {AW{1'b1}} : AW'(BLOCK_BYTES - 1);

    logic               r_op;
    logic [ADDR_W-1:0]  r_address;
    logic [DATA_W-1:0]  r_data;
    logic [DATA_W-1:0]  r_mem [ARRAY_BYTES];
    logic [DATA_W-1:0]  r_mem_q;
    logic               r_sweep;
    logic [AW-1:0]      r_ptr, r_end;
    logic [DATA_W-1:0]  r_res_data;
    logic               r_res_busy;
    logic [AW-1:0]      w_addr;
    logic [AW-1:0]      w_mask;

    assign w_addr = AW'(r_address);

    // Captured access
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_address <= i_address;
            r_data    <= i_write_data;
        end
    end

    // Region mask for the erase kind
    always_comb begin
        case (i_cmd.erase_kind)
            ER_SECTOR: w_mask = SEC_MASK;
            ER_BLOCK:  w_mask = BLK_MASK;
            default:   w_mask = {AW{1'b1}};
        endcase
    end

    // Erase sweep, one byte a cycle; the whole array after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= 1'b1;
            r_ptr   <= '0;
            r_end   <= {AW{1'b1}};
        end else if (i_cmd.erase_start) begin
            r_sweep <= 1'b1;
            r_ptr   <= w_addr & ~w_mask;
            r_end   <= w_addr | w_mask;
        end else if (r_sweep) begin
            if (r_ptr == r_end) r_sweep <= 1'b0;
            else                r_ptr   <= r_ptr + AW'(1);
        end
    end

    // Array memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_sweep)
            r_mem[r_ptr] <= ERASED_BYTE;
        else if (i_cmd.prog_wr)
            r_mem[w_addr] <= r_mem_q & r_data;
        r_mem_q <= r_mem[w_addr];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_data <= i_cmd.res_use_mem ? r_mem_q : i_cmd.res_byte;
            r_res_busy <= i_cmd.res_busy;
        end
    end

    assign o_stat.op           = r_op;
    assign o_stat.addr_lsb     = r_address[0];
    assign o_stat.low16        = r_address[15:0];
    assign o_stat.data         = r_data;
    assign o_stat.sweep_active = r_sweep;
    assign o_read_data = r_res_data;
    assign o_busy_res  = r_res_busy;

endmodule

[sv/parallel_flash_command_interface_core.sv]
// Top level of the parallel flash command interface: controller plus datapath.
// Depends on pfci_pkg, pfci_if, pfci_ctrl and pfci_dp.
//
//  channel  | modport | carries
//  ---------+---------+-------------------------------
//  i_req    | sink    | op, address, write_data
//  o_rsp    | source  | read_data, busy_res
//  i_cfg_*  | write   | register index, data
//
// An access passes through the steps accept, array read, execute and result,
// one access at a time; the array read is registered. A sector, block or chip
// erase adds an FF sweep, one byte at a time, through the single array write
// port. After reset a clearing pass sweeps the whole array before the first
// access is accepted. A stalled result holds the block; no new access is taken
// until it is delivered.
module parallel_flash_command_interface_core #(
    parameter int unsigned ARRAY_BYTES  = pfci_pkg::ARRAY_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = pfci_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES  = pfci_pkg::BLOCK_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfci_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfci_pkg::DATA_W-1:0]    i_cfg_data,
    pfci_req_if.sink                       i_req,
    pfci_rsp_if.source                     o_rsp
);
    import pfci_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    pfci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pfci_dp #(
        .ARRAY_BYTES  (ARRAY_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_req.op),
        .i_address    (i_req.address),
        .i_write_data (i_req.write_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_read_data  (o_rsp.read_data),
        .o_busy_res   (o_rsp.busy_res)
    );

endmodule

[sim/pfci_checker.sv]
`timescale 1ns / 100ps
// Result checker for the parallel flash command interface: watches the access,
// result and register-write ports, predicts every result and compares it.
// Depends on pfci_pkg and pfci_if.
module pfci_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfci_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfci_pkg::DATA_W-1:0]    i_cfg_data,
    pfci_req_if                            i_req,
    pfci_rsp_if                            i_rsp,
    output int                             o_pending,
    output int                             o_errors
);
    import pfci_pkg::*;

    localparam int unsigned ARRAY_BYTES = ARRAY_BYTES_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              busy;
    } t_result;

    logic [DATA_W-1:0] flash_img [ARRAY_BYTES];
    t_phase            cmd_phase;
    logic              id_on;
    logic [7:0]        busy_cnt;
    logic              toggle;
    logic [7:0]        manuf_id;
    logic [7:0]        dev_id;
    logic [7:0]        prog_reads;
    logic [7:0]        erase_reads;
    logic              blk_en;
    logic              chip_en;
    t_result           results_due [$];
    int                mismatches = 0;

    assign o_errors = mismatches;

    initial begin
        for (int i = 0; i < ARRAY_BYTES; i++) flash_img[i] = ERASED_BYTE;
    end

    // Fill the aligned region around the address, clipped at the array end
    function automatic void erase_span(int unsigned a, int unsigned size);
        int unsigned base;
        base = a - (a % size);
        for (int unsigned i = 0; i < size; i++)
            if (base + i < ARRAY_BYTES) flash_img[base + i] = ERASED_BYTE;
    endfunction

    // Command decoder for a write taken while not busy
    function automatic void decode_write(logic [ADDR_W-1:0] a, logic [7:0] d);
        logic [15:0] low;
        int unsigned idx;
        low = a[15:0];
        idx = a % ARRAY_BYTES;
        if (cmd_phase == PH_PROGRAM) begin
            flash_img[idx] = flash_img[idx] & d;
            busy_cnt = prog_reads;
            cmd_phase = PH_IDLE;
        end else if (d == CMD_RESET) begin
            cmd_phase = PH_IDLE;
            id_on = 1'b0;
        end else begin
            case (cmd_phase)
                PH_IDLE:
                    if (low == ADDR_UNLOCK_A && d == CMD_UNLOCK_A) cmd_phase = PH_UNLOCK_A;
                PH_UNLOCK_A:
                    cmd_phase = (low == ADDR_UNLOCK_B && d == CMD_UNLOCK_B) ?
                                PH_COMMAND : PH_IDLE;
                PH_COMMAND: begin
                    cmd_phase = PH_IDLE;
                    if (low != ADDR_UNLOCK_A) id_on = 1'b0;
                    else if (d == CMD_ID_ENTRY) id_on = 1'b1;
                    else if (d == CMD_PROGRAM) begin
                        id_on = 1'b0;
                        cmd_phase = PH_PROGRAM;
                    end else if (d == CMD_ERASE) begin
                        id_on = 1'b0;
                        cmd_phase = PH_ERASE_SETUP;
                    end else id_on = 1'b0;
                end
                PH_ERASE_SETUP:
                    cmd_phase = (low == ADDR_UNLOCK_A && d == CMD_UNLOCK_A) ?
                                PH_ERASE_UNLOCK_A : PH_IDLE;
                PH_ERASE_UNLOCK_A:
                    cmd_phase = (low == ADDR_UNLOCK_B && d == CMD_UNLOCK_B) ?
                                PH_ERASE_COMMAND : PH_IDLE;
                PH_ERASE_COMMAND: begin
                    cmd_phase = PH_IDLE;
                    if (d == CMD_SECTOR) begin
                        erase_span(idx, SECTOR_BYTES_DEF);
                        busy_cnt = erase_reads;
                    end else if (d == CMD_BLOCK && blk_en) begin
                        erase_span(idx, BLOCK_BYTES_DEF);
                        busy_cnt = erase_reads;
                    end else if (d == CMD_CHIP && chip_en && low == ADDR_UNLOCK_A) begin
                        for (int i = 0; i < ARRAY_BYTES; i++) flash_img[i] = ERASED_BYTE;
                        busy_cnt = erase_reads;
                    end else id_on = 1'b0;
                end
                default: cmd_phase = PH_IDLE;
            endcase
        end
    endfunction

    // One bus access: returns the result it produces
    function automatic t_result bus_access(logic op, logic [ADDR_W-1:0] a, logic [7:0] d);
        t_result r;
        r = '0;
        if (!op) begin
            if (busy_cnt != 0) begin
                r.data = toggle ? STATUS_TOGGLE : 8'h00;
                toggle = ~toggle;
                busy_cnt = busy_cnt - 8'd1;
                r.busy = 1'b1;
            end else if (id_on) r.data = a[0] ? dev_id : manuf_id;
            else r.data = flash_img[a % ARRAY_BYTES];
        end else begin
            if (busy_cnt == 0) decode_write(a, d);
            r.busy = (busy_cnt != 0);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cmd_phase   = PH_IDLE;
            id_on       = 1'b0;
            busy_cnt    = '0;
            toggle      = 1'b0;
            manuf_id    = 8'hBF;
            dev_id      = 8'h5B;
            prog_reads  = 8'd4;
            erase_reads = 8'd16;
            blk_en      = 1'b1;
            chip_en     = 1'b0;
            results_due.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MANUF:    manuf_id = i_cfg_data;
                    CFG_DEVICE:   dev_id = i_cfg_data;
                    CFG_PROG_BR:  prog_reads = i_cfg_data;
                    CFG_ERASE_BR: erase_reads = i_cfg_data;
                    CFG_BLOCK_EN: blk_en = i_cfg_data[0];
                    CFG_CHIP_EN:  chip_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            // result transaction
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing pending: data %h busy %b",
                                 $realtime, i_rsp.read_data, i_rsp.busy_res);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.read_data !== want.data || i_rsp.busy_res !== want.busy) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: data exp %h got %h, busy exp %b got %b",
                                     $realtime, want.data, i_rsp.read_data,
                                     want.busy, i_rsp.busy_res);
                        mismatches++;
                    end
                end
            end
            // access transaction
            if (i_req.valid && i_req.ready)
                results_due.push_back(bus_access(i_req.op, i_req.address, i_req.write_data));
        end
        o_pending = results_due.size();
    end
endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for parallel_flash_command_interface_core: drives accesses and
// register writes, stalls the result side, and reports the checker's verdict.
// Depends on pfci_pkg, pfci_if, pfci_checker and the core.
module tb_top;
    import pfci_pkg::*;

    localparam int unsigned ARRAY_BYTES = ARRAY_BYTES_DEF;
    localparam int          ACCESS_COUNT = 1650;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    int                   pending;
    int                   errors;
    int                   accesses = 0;
    int                   burst_left = 0;
    int                   blocks_left = 4;
    logic [7:0]           prog_busy = 8'd4;
    logic [7:0]           erase_busy = 8'd16;
    logic [15:0]          stall_pat = 16'hFFFF;
    int                   pat_left = 0;

    pfci_req_if req_if ();
    pfci_rsp_if rsp_if ();

    initial begin
        req_if.valid = 1'b0;
        req_if.op = 1'b0;
        req_if.address = '0;
        req_if.write_data = '0;
        rsp_if.ready = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    parallel_flash_command_interface_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    pfci_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .i_rsp      (rsp_if),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Result side: rotating stall pattern, sometimes all-ready
    always @(negedge i_clk) begin
        if (pat_left == 0) begin
            pat_left = $urandom_range(8, 64);
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (stall_pat == 0) stall_pat = 16'h0001;
        end else pat_left--;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        rsp_if.ready = stall_pat[0];
    end

    // One access transaction, sent in bursts with random gaps between them
    task automatic send(input logic op, input logic [ADDR_W-1:0] a, input logic [7:0] d);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid = 1'b1;
        req_if.op = op;
        req_if.address = a;
        req_if.write_data = d;
        do @(posedge i_clk); while (!req_if.ready);
        accesses++;
    endtask

    task automatic rd(input logic [ADDR_W-1:0] a);
        send(1'b0, a, 8'($urandom));
    endtask

    task automatic wr(input logic [ADDR_W-1:0] a, input logic [7:0] d);
        send(1'b1, a, d);
    endtask

    // AA at 5555 then 55 at 2AAA, with random bits above the decoded 16
    task automatic unlock();
        wr({2'($urandom), ADDR_UNLOCK_A}, CMD_UNLOCK_A);
        wr({2'($urandom), ADDR_UNLOCK_B}, CMD_UNLOCK_B);
    endtask

    // Hold off until every result is in, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        if (idx == CFG_PROG_BR) prog_busy = val;
        if (idx == CFG_ERASE_BR) erase_busy = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return ADDR_W'($urandom_range(0, 63));
            1: return ADDR_W'(ARRAY_BYTES - 64 + $urandom_range(0, 63));
            2: return ADDR_W'($urandom);
            default: return ADDR_W'(18'h12000 + $urandom_range(0, 255));
        endcase
    endfunction

    task automatic some_reads(input int n);
        logic [ADDR_W-1:0] a;
        a = pick_addr();
        repeat (n) rd(($urandom_range(0, 1) == 0) ? a : pick_addr());
    endtask

    // Random command sequence: mostly well formed, some broken, some noise
    task automatic random_sequence();
        int          kind;
        int          steps;
        logic [7:0]  cmd;
        kind = $urandom_range(0, 99);
        if (kind < 25) some_reads($urandom_range(1, 6));
        else if (kind < 45) begin
            unlock();
            wr({2'($urandom), ADDR_UNLOCK_A}, CMD_PROGRAM);
            wr(pick_addr(), 8'($urandom));
            some_reads($urandom_range(0, prog_busy + 2));
        end else if (kind < 55) begin
            unlock();
            wr({2'($urandom), ADDR_UNLOCK_A}, CMD_ID_ENTRY);
            some_reads($urandom_range(1, 4));
            if ($urandom_range(0, 1) == 0) wr(pick_addr(), CMD_RESET);
        end else if (kind < 72) begin
            unlock();
            wr({2'($urandom), ADDR_UNLOCK_A}, CMD_ERASE);
            unlock();
            case ($urandom_range(0, 19))
                0: cmd = CMD_CHIP;
                1: begin
                    cmd = (blocks_left > 0) ? CMD_BLOCK : CMD_SECTOR;
                    if (blocks_left > 0) blocks_left--;
                end
                2: cmd = 8'($urandom);
                default: cmd = CMD_SECTOR;
            endcase
            wr(($urandom_range(0, 1) == 0) ? pick_addr() : {2'($urandom), ADDR_UNLOCK_A}, cmd);
            some_reads($urandom_range(0, erase_busy + 2));
        end else if (kind < 85) begin
            // correct prefix cut short by a stray write
            steps = $urandom_range(0, 4);
            if (steps > 0) wr({2'($urandom), ADDR_UNLOCK_A}, CMD_UNLOCK_A);
            if (steps > 1) wr({2'($urandom), ADDR_UNLOCK_B}, CMD_UNLOCK_B);
            if (steps > 2) wr({2'($urandom), ADDR_UNLOCK_A}, CMD_ERASE);
            if (steps > 3) wr({2'($urandom), ADDR_UNLOCK_A}, CMD_UNLOCK_A);
            wr(($urandom_range(0, 1) == 0) ? pick_addr() : {2'($urandom), ADDR_UNLOCK_B},
               8'($urandom));
            some_reads($urandom_range(0, 2));
        end else
            send(1'($urandom), ADDR_W'($urandom), 8'($urandom));
    endtask

    initial begin
        int phase_end;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, program, ID mode, reset byte, chip erase
        reg_write(CFG_CHIP_EN, 8'd1);
        reg_write(CFG_ERASE_BR, 8'd1);
        rd('0);
        rd('1);
        unlock();
        wr({2'b00, ADDR_UNLOCK_A}, CMD_PROGRAM);
        wr('1, 8'h00);
        repeat (5) rd('1);
        unlock();
        wr({2'b11, ADDR_UNLOCK_A}, CMD_ID_ENTRY);
        rd(18'h2AAAA);
        rd(18'h15555);
        wr(18'h3C3C3, CMD_RESET);
        unlock();
        wr({2'b00, ADDR_UNLOCK_A}, CMD_ERASE);
        unlock();
        wr({2'b10, ADDR_UNLOCK_A}, CMD_CHIP);
        rd('1);
        rd('1);
        drain();

        // Random phases, each with fresh register settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    reg_write(CFG_MANUF, 8'h00);
                    reg_write(CFG_DEVICE, 8'hFF);
                    reg_write(CFG_PROG_BR, 8'd1);
                    reg_write(CFG_ERASE_BR, 8'd1);
                    reg_write(CFG_BLOCK_EN, 8'd1);
                    reg_write(CFG_CHIP_EN, 8'd0);
                end
                1: begin
                    reg_write(CFG_MANUF, 8'hFF);
                    reg_write(CFG_DEVICE, 8'h00);
                    reg_write(CFG_PROG_BR, 8'd255);
                    reg_write(CFG_ERASE_BR, 8'd4);
                    reg_write(CFG_BLOCK_EN, 8'd0);
                end
                2: begin
                    reg_write(CFG_MANUF, 8'($urandom));
                    reg_write(CFG_PROG_BR, 8'd3);
                    reg_write(CFG_ERASE_BR, 8'd255);
                    reg_write(CFG_BLOCK_EN, 8'd1);
                end
                default: begin
                    reg_write(CFG_MANUF, 8'($urandom));
                    reg_write(CFG_DEVICE, 8'($urandom));
                    reg_write(CFG_PROG_BR, 8'($urandom_range(1, 8)));
                    reg_write(CFG_ERASE_BR, 8'($urandom_range(1, 8)));
                    reg_write(CFG_BLOCK_EN, 8'($urandom_range(0, 1)));
                end
            endcase
            phase_end = accesses + (ACCESS_COUNT - 25) / 6;
            while (accesses < phase_end) random_sequence();
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #80000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

[parallel_flash_command_interface_core.f]
sv/pfci_pkg.sv
sv/pfci_if.sv
sv/pfci_ctrl.sv
sv/pfci_dp.sv
sv/parallel_flash_command_interface_core.sv
sim/pfci_checker.sv
sim/tb_top.sv
